// File: rtl/rmsd_pkg.sv
// shared constants, types and state encoding for the rmsd accumulator
// no dependencies; compiled first
package rmsd_pkg;

  localparam int MAX_PAIRS  = 65536;
  localparam int COORD_W    = 25;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int SQ_W       = 2 * DIFF_W;
  localparam int D2_W       = SQ_W + 2;
  localparam int SUM_W      = 64;
  localparam int CNT_W      = $clog2(MAX_PAIRS + 1);
  localparam int RMSD_W     = 32;
  localparam int PCNT_W     = 17;
  localparam int DIV_STEPS  = SUM_W;
  localparam int ROOT_STEPS = SUM_W / 2;
  localparam int STEP_W     = $clog2(DIV_STEPS);
  localparam int SREM_W     = RMSD_W + 1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ADD,
    ST_ACC,
    ST_DIV_PREP,
    ST_DIV,
    ST_ROOT_PREP,
    ST_ROOT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load_in;
    logic square;
    logic add;
    logic accumulate;
    logic div_init;
    logic div_step;
    logic root_init;
    logic root_step;
    logic emit;
  } dp_cmd_t;

endpackage

// File: rtl/rmsd_if.sv
// channel interfaces for the pair input and the result output
// depends on rmsd_pkg
interface rmsd_in_if;
  import rmsd_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] ref_x;
  logic signed [COORD_W-1:0] ref_y;
  logic signed [COORD_W-1:0] ref_z;
  logic signed [COORD_W-1:0] model_x;
  logic signed [COORD_W-1:0] model_y;
  logic signed [COORD_W-1:0] model_z;
  logic                      last_pair;

  modport source (output valid, ref_x, ref_y, ref_z, model_x, model_y, model_z, last_pair,
                  input ready);
  modport sink (input valid, ref_x, ref_y, ref_z, model_x, model_y, model_z, last_pair,
                output ready);
endinterface

interface rmsd_out_if;
  import rmsd_pkg::*;
  logic              valid;
  logic              ready;
  logic [RMSD_W-1:0] rmsd_value;
  logic [PCNT_W-1:0] pair_count;
  logic              sum_saturated;

  modport source (output valid, rmsd_value, pair_count, sum_saturated, input ready);
  modport sink (input valid, rmsd_value, pair_count, sum_saturated, output ready);
endinterface

// File: rtl/rmsd_ctrl.sv
// controller: sequences accumulate, divide and square root steps
// depends on rmsd_pkg
module rmsd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  logic              last_flag,
  output rmsd_pkg::dp_cmd_t cmd
);
  import rmsd_pkg::*;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_SQUARE;
      end
      ST_SQUARE:   state_nxt = ST_ADD;
      ST_ADD:      state_nxt = ST_ACC;
      ST_ACC:      state_nxt = last_flag ? ST_DIV_PREP : ST_IDLE;
      ST_DIV_PREP: begin
        state_nxt = ST_DIV;
        step_nxt  = STEP_W'(DIV_STEPS - 1);
      end
      ST_DIV: begin
        step_nxt = step_r - 1'b1;
        if (step_r == '0) state_nxt = ST_ROOT_PREP;
      end
      ST_ROOT_PREP: begin
        state_nxt = ST_ROOT;
        step_nxt  = STEP_W'(ROOT_STEPS - 1);
      end
      ST_ROOT: begin
        step_nxt = step_r - 1'b1;
        if (step_r == '0) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      ST_SQUARE:    cmd.square     = 1'b1;
      ST_ADD:       cmd.add        = 1'b1;
      ST_ACC:       cmd.accumulate = 1'b1;
      ST_DIV_PREP:  cmd.div_init   = 1'b1;
      ST_DIV:       cmd.div_step   = 1'b1;
      ST_ROOT_PREP: cmd.root_init  = 1'b1;
      ST_ROOT:      cmd.root_step  = 1'b1;
      ST_EMIT: begin
        if (out_free) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: rtl/rmsd_dp.sv
// datapath: squared distance, saturating sum, restoring divide, digit root
// depends on rmsd_pkg; driven by rmsd_ctrl commands
module rmsd_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  rmsd_pkg::dp_cmd_t                  cmd,
  input  logic signed [rmsd_pkg::COORD_W-1:0] ref_x,
  input  logic signed [rmsd_pkg::COORD_W-1:0] ref_y,
  input  logic signed [rmsd_pkg::COORD_W-1:0] ref_z,
  input  logic signed [rmsd_pkg::COORD_W-1:0] model_x,
  input  logic signed [rmsd_pkg::COORD_W-1:0] model_y,
  input  logic signed [rmsd_pkg::COORD_W-1:0] model_z,
  input  logic                               last_pair,
  output logic                               last_flag,
  output logic [rmsd_pkg::RMSD_W-1:0]        rmsd_value,
  output logic [rmsd_pkg::PCNT_W-1:0]        pair_count,
  output logic                               sum_saturated
);
  import rmsd_pkg::*;

  logic signed [DIFF_W-1:0] dx_r, dy_r, dz_r;
  logic signed [SQ_W-1:0]   px, py, pz;
  logic [SQ_W-1:0]          sqx_r, sqy_r, sqz_r;
  logic [D2_W-1:0]          d2_r;
  logic                     last_r;
  logic [SUM_W-1:0]         sum_r;
  logic [CNT_W-1:0]         cnt_r;
  logic                     sat_r;
  logic [SUM_W:0]           sum_ext;
  logic [SUM_W-1:0]         q_r;
  logic [CNT_W-1:0]         drem_r;
  logic [CNT_W:0]           drem_sh;
  logic [RMSD_W-1:0]        root_r;
  logic [SREM_W-1:0]        srem_r;
  logic [SREM_W+1:0]        srem_sh;
  logic [SREM_W+1:0]        trial;
  logic [RMSD_W-1:0]        out_rmsd_r;
  logic [PCNT_W-1:0]        out_cnt_r;
  logic                     out_sat_r;

  assign px      = dx_r * dx_r;
  assign py      = dy_r * dy_r;
  assign pz      = dz_r * dz_r;
  assign sum_ext = {1'b0, sum_r} + (SUM_W + 1)'(d2_r);
  assign drem_sh = {drem_r, q_r[SUM_W-1]};
  assign srem_sh = {srem_r, q_r[SUM_W-1 -: 2]};
  assign trial   = (SREM_W + 2)'({root_r, 2'b01});

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      dx_r   <= {ref_x[COORD_W-1], ref_x} - {model_x[COORD_W-1], model_x};
      dy_r   <= {ref_y[COORD_W-1], ref_y} - {model_y[COORD_W-1], model_y};
      dz_r   <= {ref_z[COORD_W-1], ref_z} - {model_z[COORD_W-1], model_z};
      last_r <= last_pair;
    end
    if (cmd.square) begin
      sqx_r <= px;
      sqy_r <= py;
      sqz_r <= pz;
    end
    if (cmd.add) d2_r <= D2_W'(sqx_r) + D2_W'(sqy_r) + D2_W'(sqz_r);

    // restoring divide of the sum by the pair count, quotient left in q_r
    if (cmd.div_init) begin
      q_r    <= sum_r;
      drem_r <= '0;
    end else if (cmd.div_step) begin
      if (drem_sh >= (CNT_W + 1)'(cnt_r)) begin
        drem_r <= CNT_W'(drem_sh - (CNT_W + 1)'(cnt_r));
        q_r    <= {q_r[SUM_W-2:0], 1'b1};
      end else begin
        drem_r <= drem_sh[CNT_W-1:0];
        q_r    <= {q_r[SUM_W-2:0], 1'b0};
      end
    end else if (cmd.root_step) begin
      q_r <= {q_r[SUM_W-3:0], 2'b00};
    end

    // two bits of radicand per step
    if (cmd.root_init) begin
      root_r <= '0;
      srem_r <= '0;
    end else if (cmd.root_step) begin
      if (srem_sh >= trial) begin
        srem_r <= SREM_W'(srem_sh - trial);
        root_r <= {root_r[RMSD_W-2:0], 1'b1};
      end else begin
        srem_r <= srem_sh[SREM_W-1:0];
        root_r <= {root_r[RMSD_W-2:0], 1'b0};
      end
    end

    if (cmd.emit) begin
      out_rmsd_r <= root_r;
      out_cnt_r  <= PCNT_W'(cnt_r);
      out_sat_r  <= sat_r;
    end
  end

  // accumulator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
      sat_r <= 1'b0;
    end else if (cmd.emit) begin
      sum_r <= '0;
      cnt_r <= '0;
      sat_r <= 1'b0;
    end else if (cmd.accumulate && (cnt_r != CNT_W'(MAX_PAIRS))) begin
      cnt_r <= cnt_r + 1'b1;
      if (sum_ext[SUM_W]) begin
        sum_r <= '1;
        sat_r <= 1'b1;
      end else begin
        sum_r <= sum_ext[SUM_W-1:0];
      end
    end
  end

  assign last_flag     = last_r;
  assign rmsd_value    = out_rmsd_r;
  assign pair_count    = out_cnt_r;
  assign sum_saturated = out_sat_r;

endmodule

// File: rtl/rmsd_accumulator_unit.sv
// top level of the rmsd accumulator: controller plus datapath
// depends on rmsd_pkg, rmsd_if, rmsd_ctrl and rmsd_dp
//
//  channel  | role   | transfer moves
//  ---------+--------+------------------------------------------------
//  in_ch    | sink   | one reference/model point pair and last_pair
//  out_ch   | source | rmsd_value, pair_count, sum_saturated
//
// a pair that is not last goes through capture, square, sum of squares and
// accumulate; in_ch.ready is high only in the idle state
// a last pair then adds a prepare step and a restoring divide (one quotient
// bit per cycle), a prepare step and a square root (one root bit per cycle),
// and a load of the output register
// the result sits in an output register; the next pair is taken while it
// waits, and only the next result load stalls until out_ch transfers
// synchronous active-low reset clears the sum, the count, the flag and control
module rmsd_accumulator_unit (
  input  logic       clk,
  input  logic       rst_n,
  rmsd_in_if.sink    in_ch,
  rmsd_out_if.source out_ch
);
  import rmsd_pkg::*;

  dp_cmd_t cmd;
  logic    last_flag;

  // sequencing of the accumulate, divide and root steps
  rmsd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .last_flag (last_flag),
    .cmd       (cmd)
  );

  // arithmetic and the result register
  rmsd_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .ref_x         (in_ch.ref_x),
    .ref_y         (in_ch.ref_y),
    .ref_z         (in_ch.ref_z),
    .model_x       (in_ch.model_x),
    .model_y       (in_ch.model_y),
    .model_z       (in_ch.model_z),
    .last_pair     (in_ch.last_pair),
    .last_flag     (last_flag),
    .rmsd_value    (out_ch.rmsd_value),
    .pair_count    (out_ch.pair_count),
    .sum_saturated (out_ch.sum_saturated)
  );

endmodule

// File: tb/tb_rmsd_accumulator_unit.sv
// self-checking testbench for rmsd_accumulator_unit: a directed table and random sets,
// checked against an rmsd predictor kept inside the testbench
// depends on rmsd_pkg, rmsd_in_if, rmsd_out_if and the rmsd_accumulator_unit rtl
`timescale 1ns / 1ps

module tb_rmsd_accumulator_unit;
  import rmsd_pkg::*;

  // coordinate extremes: full 25-bit range and the stated in-range limit
  localparam int C_MIN = -(1 << (COORD_W - 1));
  localparam int C_MAX = (1 << (COORD_W - 1)) - 1;
  localparam int IN_HI = 9999999;

  localparam int RANDOM_ITEMS = 920;
  localparam int IDLE_LIMIT   = 1000;   // a last pair needs the divide and root steps plus stalls
  localparam int DRAIN_CYCLES = 150;
  localparam int PRINT_CAP    = 100;

  typedef struct packed {
    logic [COORD_W-1:0] ref_x;
    logic [COORD_W-1:0] ref_y;
    logic [COORD_W-1:0] ref_z;
    logic [COORD_W-1:0] model_x;
    logic [COORD_W-1:0] model_y;
    logic [COORD_W-1:0] model_z;
    logic               last_pair;
  } pair_t;

  typedef struct packed {
    logic [RMSD_W-1:0] rmsd_value;
    logic [PCNT_W-1:0] pair_count;
    logic              sum_saturated;
  } rmsd_res_t;

  // one row of the directed table; typed rows carry their own expected result
  typedef struct packed {
    pair_t     pair;
    logic      typed;
    rmsd_res_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  rmsd_in_if  in_ch ();
  rmsd_out_if out_ch ();

  rmsd_accumulator_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #2 clk = ~clk;

  // predictor state for the set in progress
  logic [SUM_W-1:0] set_sum;
  int unsigned      set_pairs;
  logic             set_sat;

  rmsd_res_t   rmsd_expect_q[$];
  int          mismatch_count;
  int          idle_cycles;
  bit          in_burst;      // no sender gaps for the current set
  stim_row_t   dir_rows[$];

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_CAP)
      $display("%0t ns mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // append one row to the directed table
  task automatic add_row(input pair_t p, input logic typed, input rmsd_res_t want);
    stim_row_t row;
    row.pair  = p;
    row.typed = typed;
    row.want  = want;
    dir_rows.insert(dir_rows.size(), row);
  endtask

  // squared difference of one axis, exact at 64 bits
  function automatic logic [63:0] axis_sq(input logic [COORD_W-1:0] a,
                                          input logic [COORD_W-1:0] b);
    logic signed [DIFF_W-1:0] d;
    logic [63:0]              m;
    d = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
    m = '0;
    m[DIFF_W-1:0] = (d < 0) ? -d : d;
    return m * m;
  endfunction

  // floor square root, one root bit at a time from the top
  function automatic logic [RMSD_W-1:0] int_sqrt(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int b = RMSD_W - 1; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v)
        r = t;
    end
    return r[RMSD_W-1:0];
  endfunction

  // fold one accepted pair into the running set; a last pair closes the set
  task automatic fold_pair(input pair_t p, output bit emits, output rmsd_res_t res);
    logic [SUM_W:0]   s;
    logic [SUM_W-1:0] divisor;
    logic [SUM_W-1:0] mean;
    emits = 1'b0;
    res   = '0;
    // pairs past the count limit are dropped but still honor last_pair
    if (set_pairs < MAX_PAIRS) begin
      s = {1'b0, set_sum} + (axis_sq(p.ref_x, p.model_x) + axis_sq(p.ref_y, p.model_y) +
                             axis_sq(p.ref_z, p.model_z));
      if (s[SUM_W]) begin
        set_sum = '1;
        set_sat = 1'b1;
      end else begin
        set_sum = s[SUM_W-1:0];
      end
      set_pairs++;
    end
    if (p.last_pair) begin
      divisor = (set_pairs == 0) ? 64'd1 : 64'(set_pairs);
      mean    = set_sum / divisor;
      res.rmsd_value    = int_sqrt(mean);
      res.pair_count    = set_pairs[PCNT_W-1:0];
      res.sum_saturated = set_sat;
      emits     = 1'b1;
      set_sum   = '0;
      set_pairs = 0;
      set_sat   = 1'b0;
    end
  endtask

  function automatic pair_t mk_pair(input int rx, input int ry, input int rz,
                                    input int mx, input int my, input int mz,
                                    input bit last);
    pair_t p;
    p.ref_x     = rx[COORD_W-1:0];
    p.ref_y     = ry[COORD_W-1:0];
    p.ref_z     = rz[COORD_W-1:0];
    p.model_x   = mx[COORD_W-1:0];
    p.model_y   = my[COORD_W-1:0];
    p.model_z   = mz[COORD_W-1:0];
    p.last_pair = last;
    return p;
  endfunction

  function automatic rmsd_res_t mk_res(input int unsigned rmsd, input int unsigned cnt,
                                       input bit sat);
    rmsd_res_t r;
    r.rmsd_value    = rmsd;
    r.pair_count    = cnt[PCNT_W-1:0];
    r.sum_saturated = sat;
    return r;
  endfunction

  // mostly in-range values, some raw 25-bit patterns, some extremes
  function automatic logic [COORD_W-1:0] rand_coord();
    int v;
    case ($urandom_range(0, 9)) inside
      [0:5]: v = int'($urandom_range(0, 2 * IN_HI)) - IN_HI;
      [6:7]: v = $urandom;
      default:
        case ($urandom_range(0, 5))
          0: v = C_MIN;
          1: v = C_MAX;
          2: v = IN_HI;
          3: v = -IN_HI;
          4: v = -1;
          default: v = 0;
        endcase
    endcase
    return v[COORD_W-1:0];
  endfunction

  // small offset so that some sets give small, close-to-boundary roots
  function automatic logic [COORD_W-1:0] jitter();
    int v;
    v = int'($urandom_range(0, 2000)) - 1000;
    return v[COORD_W-1:0];
  endfunction

  function automatic pair_t rand_pair(input bit last);
    pair_t p;
    p.ref_x = rand_coord();
    p.ref_y = rand_coord();
    p.ref_z = rand_coord();
    if ($urandom_range(0, 9) < 3) begin
      p.model_x = p.ref_x + jitter();
      p.model_y = p.ref_y + jitter();
      p.model_z = p.ref_z + jitter();
    end else begin
      p.model_x = rand_coord();
      p.model_y = rand_coord();
      p.model_z = rand_coord();
    end
    p.last_pair = last;
    return p;
  endfunction

  // drive one pair, hold it until the block takes it, then predict
  task automatic send_pair(input pair_t p, input bit typed, input rmsd_res_t typed_res);
    int        gap;
    bit        emits;
    rmsd_res_t res;
    gap = in_burst ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.ref_x     <= p.ref_x;
    in_ch.ref_y     <= p.ref_y;
    in_ch.ref_z     <= p.ref_z;
    in_ch.model_x   <= p.model_x;
    in_ch.model_y   <= p.model_y;
    in_ch.model_z   <= p.model_z;
    in_ch.last_pair <= p.last_pair;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    // transfer happened at this edge
    fold_pair(p, emits, res);
    if (emits)
      rmsd_expect_q.insert(rmsd_expect_q.size(), typed ? typed_res : res);
  endtask

  // result side: stall a random number of cycles per result, sometimes not at all
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (stall == 0) begin
        out_ch.ready <= 1'b1;
      end else begin
        // hold off with the result already waiting
        out_ch.ready <= 1'b0;
        @(posedge clk);
        while (!out_ch.valid) @(posedge clk);
        repeat (stall - 1) @(posedge clk);
        out_ch.ready <= 1'b1;
      end
      @(posedge clk);
      while (!(out_ch.valid && out_ch.ready)) @(posedge clk);
    end
  end

  // result checker: each transfer against the oldest expectation
  always @(posedge clk) begin
    rmsd_res_t got;
    rmsd_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.rmsd_value    = out_ch.rmsd_value;
      got.pair_count    = out_ch.pair_count;
      got.sum_saturated = out_ch.sum_saturated;
      if (rmsd_expect_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result rmsd=%0d count=%0d sat=%0b",
                                  got.rmsd_value, got.pair_count, got.sum_saturated));
      end else begin
        want = rmsd_expect_q.pop_front();
        if (got.rmsd_value !== want.rmsd_value)
          report_mismatch($sformatf("rmsd_value %0d, want %0d",
                                    got.rmsd_value, want.rmsd_value));
        if (got.pair_count !== want.pair_count)
          report_mismatch($sformatf("pair_count %0d, want %0d",
                                    got.pair_count, want.pair_count));
        if (got.sum_saturated !== want.sum_saturated)
          report_mismatch($sformatf("sum_saturated %0b, want %0b",
                                    got.sum_saturated, want.sum_saturated));
      end
    end
  end

  // watchdog: ends the run after too many cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("rmsd_accumulator_unit regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int len;
    int random_items;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.ref_x     <= '0;
    in_ch.ref_y     <= '0;
    in_ch.ref_z     <= '0;
    in_ch.model_x   <= '0;
    in_ch.model_y   <= '0;
    in_ch.model_z   <= '0;
    in_ch.last_pair <= 1'b0;
    in_burst        = 1'b0;
    set_sum         = '0;
    set_pairs       = 0;
    set_sat         = 1'b0;
    random_items    = 0;

    // directed table
    // zero distance right after reset
    add_row(mk_pair(0, 0, 0, 0, 0, 0, 1), 1'b1, mk_res(0, 1, 0));
    // largest single-axis distance, both signs
    add_row(mk_pair(C_MIN, 0, 0, C_MAX, 0, 0, 1), 1'b1, mk_res(C_MAX - C_MIN, 1, 0));
    add_row(mk_pair(C_MAX, 0, 0, C_MIN, 0, 0, 1), 1'b1, mk_res(C_MAX - C_MIN, 1, 0));
    // in-range extremes on y and z
    add_row(mk_pair(0, IN_HI, 0, 0, -IN_HI, 0, 1), 1'b1, mk_res(2 * IN_HI, 1, 0));
    add_row(mk_pair(0, 0, -IN_HI, 0, 0, IN_HI, 1), 1'b1, mk_res(2 * IN_HI, 1, 0));
    // identical points at the field extremes
    add_row(mk_pair(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, 1), 1'b1, mk_res(0, 1, 0));
    add_row(mk_pair(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, 1), 1'b1, mk_res(0, 1, 0));
    add_row(mk_pair(-1, -1, -1, -1, -1, -1, 1), 1'b1, mk_res(0, 1, 0));
    // 3-4-5 triangle, then the same over two pairs (floor of 25/2)
    add_row(mk_pair(3, 4, 0, 0, 0, 0, 1), 1'b1, mk_res(5, 1, 0));
    add_row(mk_pair(3, 4, 0, 0, 0, 0, 0), 1'b0, '0);
    add_row(mk_pair(0, 0, 0, 0, 0, 0, 1), 1'b1, mk_res(3, 2, 0));
    // largest distance on all three axes
    add_row(mk_pair(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, 1), 1'b0, '0);
    // multi-pair set with mixed signs
    add_row(mk_pair(-5, -7, -1, 5, 7, 1, 0), 1'b0, '0);
    add_row(mk_pair(IN_HI, -IN_HI, 12345, -IN_HI, IN_HI, -54321, 0), 1'b0, '0);
    add_row(mk_pair(1, 1, 1, 0, 0, -1, 0), 1'b0, '0);
    add_row(mk_pair(C_MAX, 0, C_MIN, -1, -1, -1, 1), 1'b0, '0);
    // sums just under and at a perfect square
    add_row(mk_pair(3, 2, 1, 0, 0, 0, 1), 1'b0, '0);
    add_row(mk_pair(4, 0, 0, 0, 0, 0, 1), 1'b1, mk_res(4, 1, 0));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      send_pair(dir_rows[i].pair, dir_rows[i].typed, dir_rows[i].want);

    // random sets, mostly short so that results come often
    while (random_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9)) inside
        0: len = 1;
        [1:6]: len = $urandom_range(2, 6);
        [7:8]: len = $urandom_range(7, 30);
        default: len = $urandom_range(31, 120);
      endcase
      in_burst = ($urandom_range(0, 3) == 0);
      for (int j = 0; j < len; j++)
        send_pair(rand_pair(j == len - 1), 1'b0, '0);
      random_items += len;
    end

    in_ch.valid <= 1'b0;
    while (rmsd_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("rmsd_accumulator_unit regression: pass");
    else
      $display("rmsd_accumulator_unit regression: fail");
    $finish;
  end

endmodule

// File: rmsd_accumulator_unit.f
rtl/rmsd_pkg.sv
rtl/rmsd_if.sv
rtl/rmsd_ctrl.sv
rtl/rmsd_dp.sv
rtl/rmsd_accumulator_unit.sv
tb/tb_rmsd_accumulator_unit.sv
